// ===== sv/gba_pkg.sv =====
// ----------------------------------------------------------------------------
// gba_pkg
// Shared constants, types and helper functions for the grouped bitmap
// block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gba_pkg;

    localparam int NUM_GROUPS       = 8;
    localparam int BLOCKS_PER_GROUP = 8192;

    localparam int TOTAL_BLOCKS    = NUM_GROUPS * BLOCKS_PER_GROUP;
    localparam int WORD_BITS       = 64;
    localparam int BIT_W           = $clog2(WORD_BITS);
    localparam int BITMAP_WORDS    = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORDS_PER_GROUP = BLOCKS_PER_GROUP / WORD_BITS;
    localparam int WORD_AW         = $clog2(BITMAP_WORDS);
    localparam int WPG_W           = $clog2(WORDS_PER_GROUP);
    localparam int GRP_W           = $clog2(NUM_GROUPS);
    localparam int POS_W           = $clog2(TOTAL_BLOCKS);
    localparam int GF_W            = $clog2(BLOCKS_PER_GROUP + 1);
    localparam int TF_W            = $clog2(TOTAL_BLOCKS + 1);

    // fixed field widths
    localparam int BLK_W  = 17;
    localparam int STAT_W = 2;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PICK,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } state_t;

    // count update command to the counter block
    typedef struct packed {
        logic             inc;
        logic             dec;
        logic [GRP_W-1:0] grp;
    } cnt_cmd_t;

    // bitmap write port
    typedef struct packed {
        logic                 we;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] data;
    } ram_wr_t;

    // index of the lowest clear bit of a bitmap word
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // index of the lowest set bit of a group mask
    function automatic logic [GRP_W-1:0] lowest_set(input logic [NUM_GROUPS-1:0] m);
        logic [GRP_W-1:0] idx;
        idx = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = GRP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gba_if.sv =====
// ----------------------------------------------------------------------------
// gba_if
// Valid/ready channels of the allocator: request, response and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface gba_req_if
    import gba_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [BLK_W-1:0] block_number;

    modport source (output valid, output req_type, output block_number, input ready);
    modport sink   (input valid, input req_type, input block_number, output ready);
endinterface

interface gba_rsp_if
    import gba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BLK_W-1:0]  allocated_block;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  total_free;

    modport source (output valid, output allocated_block, output status,
                    output total_free, input ready);
    modport sink   (input valid, input allocated_block, input status,
                    input total_free, output ready);
endinterface

interface gba_cfg_if
    import gba_pkg::*;
();
    logic valid;
    logic ready;
    logic first_data_block;

    modport source (output valid, output first_data_block, input ready);
    modport sink   (input valid, input first_data_block, output ready);
endinterface

`default_nettype wire

// ===== sv/gba_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// gba_bitmap_ram
// Block bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_bitmap_ram
    import gba_pkg::*;
(
    input  wire logic                 clk,
    input  wire ram_wr_t              wr,
    input  wire logic [WORD_AW-1:0]   raddr,
    output      logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/gba_counts.sv =====
// ----------------------------------------------------------------------------
// gba_counts
// Per-group free counts and the device total, with the nonzero group mask.
// ----------------------------------------------------------------------------
`default_nettype none

module gba_counts
    import gba_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cnt_cmd_t              cmd,
    output      logic [NUM_GROUPS-1:0] nz_mask,
    output      logic [TF_W-1:0]       free_total
);

    logic [GF_W-1:0] group_free_reg [NUM_GROUPS];
    logic [TF_W-1:0] total_reg;
    logic [TF_W-1:0] total_next;

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            nz_mask[g] = (group_free_reg[g] != '0);
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (cmd.inc)
        begin
            total_next = total_reg + TF_W'(1);
        end
        else if (cmd.dec && total_reg != '0)
        begin
            total_next = total_reg - TF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_free_reg[g] <= GF_W'(BLOCKS_PER_GROUP);
            end
            total_reg <= TF_W'(TOTAL_BLOCKS);
        end
        else
        begin
            if (cmd.inc)
            begin
                group_free_reg[cmd.grp] <= group_free_reg[cmd.grp] + GF_W'(1);
            end
            else if (cmd.dec)
            begin
                group_free_reg[cmd.grp] <= group_free_reg[cmd.grp] - GF_W'(1);
            end
            total_reg <= total_next;
        end
    end

    assign free_total = total_reg;

endmodule

`default_nettype wire

// ===== sv/grouped_bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// First-fit block allocator over a grouped bitmap with free counts.
// Allocate: pick a group in S_PICK, read one bitmap word per cycle over the
//   group (up to 128 words), then set the found bit and post the response
//   from S_DONE; when no block is free S_PICK goes straight to S_DONE.
// Free: read and check the word, write it back if the block was in use, post
//   result; an out-of-range block is answered without a read.
// One request at a time; the bitmap read port paces the scan.
// After reset a clearing pass zeroes the bitmap (1024 words), no request
//   is taken meanwhile; config writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_bitmap_block_allocator
    import gba_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    gba_cfg_if.sink  cfg,
    gba_req_if.sink  req,
    gba_rsp_if.source rsp
);

    state_t state_reg, state_next;

    logic                  fdb_reg;
    logic [WORD_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [WORD_AW-1:0]    scan_addr_reg, scan_addr_next;
    logic                  issue_en_reg, issue_en_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [WORD_AW-1:0]    chk_addr_reg, chk_addr_next;
    logic [NUM_GROUPS-1:0] skip_reg, skip_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [BLK_W-1:0]      res_block_reg, res_block_next;
    logic [STAT_W-1:0]     res_status_reg, res_status_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [BLK_W-1:0]      rsp_block_reg, rsp_block_next;
    logic [STAT_W-1:0]     rsp_status_reg, rsp_status_next;
    logic [BLK_W-1:0]      rsp_total_reg, rsp_total_next;

    ram_wr_t               ram_wr;
    logic [WORD_AW-1:0]    ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;
    cnt_cmd_t              cnt_cmd;
    logic [NUM_GROUPS-1:0] nz_mask;
    logic [TF_W-1:0]       free_total;

    logic [NUM_GROUPS-1:0] cand;
    logic [BLK_W-1:0]      pos_full;
    logic                  out_of_range;
    logic [BIT_W-1:0]      zidx;
    logic [GRP_W-1:0]      chk_grp;
    logic                  out_slot_free;

    gba_bitmap_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gba_counts u_counts (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cnt_cmd),
        .nz_mask    (nz_mask),
        .free_total (free_total)
    );

    assign cfg.ready     = 1'b1;
    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.allocated_block = rsp_block_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.total_free = rsp_total_reg;

    assign cand          = nz_mask & ~skip_reg;
    assign pos_full      = req.block_number - BLK_W'(fdb_reg);
    assign out_of_range  = (req.block_number < BLK_W'(fdb_reg))
                         || (pos_full >= BLK_W'(TOTAL_BLOCKS));
    assign zidx          = lowest_zero(ram_rdata);
    assign chk_grp       = chk_addr_reg[WORD_AW-1:WPG_W];
    assign out_slot_free = !rsp_valid_reg || rsp.ready;
    assign ram_raddr     = (state_reg == S_FREE_RD) ? pos_reg[POS_W-1:BIT_W]
                                                     : scan_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        issue_en_next   = issue_en_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = chk_addr_reg;
        skip_next       = skip_reg;
        pos_next        = pos_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_block_next  = rsp_block_reg;
        rsp_status_next = rsp_status_reg;
        rsp_total_next  = rsp_total_reg;
        ram_wr          = '{we: 1'b0, addr: chk_addr_reg, data: ram_rdata};
        cnt_cmd         = '{inc: 1'b0, dec: 1'b0, grp: chk_grp};

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr        = '{we: 1'b1, addr: clr_addr_reg, data: '0};
                clr_addr_next = clr_addr_reg + WORD_AW'(1);
                if (clr_addr_reg == WORD_AW'(BITMAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_ALLOC)
                    begin
                        skip_next  = '0;
                        state_next = S_PICK;
                    end
                    else if (out_of_range)
                    begin
                        res_block_next  = '0;
                        res_status_next = ST_OUT_OF_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_full[POS_W-1:0];
                        state_next = S_FREE_RD;
                    end
                end
            end

            S_PICK:
            begin
                if (cand == '0)
                begin
                    res_block_next  = '0;
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_addr_next = {lowest_set(cand), WPG_W'(0)};
                    issue_en_next  = 1'b1;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, data checked in the cycle after
                if (issue_en_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_addr_reg;
                    scan_addr_next = scan_addr_reg + WORD_AW'(1);
                    issue_en_next  = (scan_addr_reg[WPG_W-1:0] != WPG_W'(WORDS_PER_GROUP - 1));
                end
                if (chk_valid_reg)
                begin
                    if (ram_rdata != '1)
                    begin
                        ram_wr          = '{we: 1'b1, addr: chk_addr_reg,
                                            data: ram_rdata | (WORD_BITS'(1) << zidx)};
                        cnt_cmd.dec     = 1'b1;
                        res_block_next  = BLK_W'({chk_addr_reg, zidx}) + BLK_W'(fdb_reg);
                        res_status_next = ST_OK;
                        chk_valid_next  = 1'b0;
                        issue_en_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                    else if (chk_addr_reg[WPG_W-1:0] == WPG_W'(WORDS_PER_GROUP - 1))
                    begin
                        // count said free but the group is full: try the next one
                        skip_next[chk_grp] = 1'b1;
                        chk_valid_next     = 1'b0;
                        state_next         = S_PICK;
                    end
                end
            end

            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                res_block_next = '0;
                if (!ram_rdata[pos_reg[BIT_W-1:0]])
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    ram_wr          = '{we: 1'b1, addr: pos_reg[POS_W-1:BIT_W],
                                        data: ram_rdata & ~(WORD_BITS'(1) << pos_reg[BIT_W-1:0])};
                    cnt_cmd.inc     = 1'b1;
                    cnt_cmd.grp     = pos_reg[POS_W-1:POS_W-GRP_W];
                    res_status_next = ST_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_block_next  = res_block_reg;
                    rsp_status_next = res_status_reg;
                    rsp_total_next  = BLK_W'(free_total);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            issue_en_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            skip_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            fdb_reg       <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            issue_en_reg  <= issue_en_next;
            chk_valid_reg <= chk_valid_next;
            skip_reg      <= skip_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                fdb_reg <= cfg.first_data_block;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg  <= scan_addr_next;
        chk_addr_reg   <= chk_addr_next;
        pos_reg        <= pos_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        rsp_block_reg  <= rsp_block_next;
        rsp_status_reg <= rsp_status_next;
        rsp_total_reg  <= rsp_total_next;
    end

    // no request taken during the clearing pass
    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request accepted during bitmap clear");

    // a grant only comes from a group whose count is nonzero
    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_cmd.dec |-> nz_mask[cnt_cmd.grp])
        else $error("count lowered in an empty group");

    // bitmap is only written while clearing or updating a word
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.we |-> (state_reg == S_CLEAR || state_reg == S_SCAN
                       || state_reg == S_FREE_CHK))
        else $error("bitmap write outside an update state");

    // a finished request posts its word and returns to idle
    a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_slot_free) |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("finished request did not post a response");

endmodule

`default_nettype wire

// ===== verif/tb_grouped_bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_grouped_bitmap_block_allocator
// Self-checking bench for the first-fit grouped bitmap block allocator.
// A directed sequence covers block zero, reuse of freed holes, frees below and
// beyond the device and frees of blocks that are not in use. Random phases
// under both first-data-block settings then mix allocations, frees of granted
// blocks and stray frees. Each response is checked against a bit-level
// mirror of the bitmap and free counts, with random gaps on both channels and
// one long response stall.
// ----------------------------------------------------------------------------
module tb_grouped_bitmap_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import gba_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_WORDS  = 490;
    localparam int SETTLE_TICKS = 140;
    localparam int STALL_TICKS  = 600;

    typedef struct packed {
        logic             req_type;
        logic [BLK_W-1:0] block_number;
    } alloc_req_t;

    typedef struct packed {
        logic [BLK_W-1:0]  block;
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  total_free;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    gba_cfg_if cfg_ch ();
    gba_req_if req_ch ();
    gba_rsp_if rsp_ch ();

    grouped_bitmap_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the allocator state
    bit [WORD_BITS-1:0] used_map [BITMAP_WORDS];
    int                 group_left [NUM_GROUPS];
    int                 blocks_left = TOTAL_BLOCKS;
    bit                 first_blk = 1'b1;
    int                 live_pos [$];   // granted positions, used to aim frees

    alloc_req_t pending_reqs [$];
    alloc_rsp_t expected_rsps [$];

    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    int   accepted_reqs = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    bit   stall_done = 1'b0;
    int   req_gap = 0;
    int   req_quiet = 0;
    int   rsp_gap = 0;
    int   rsp_quiet = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // per-word wait, with occasional stretches of back-to-back traffic
    function automatic int pick_wait(inout int quiet_left);
        int w;
        w = 0;
        if (quiet_left > 0)
            quiet_left--;
        else if ($urandom_range(0, 15) == 0)
            quiet_left = 24;
        else
            w = $urandom_range(0, 4);
        return w;
    endfunction

    function automatic alloc_rsp_t serve_request(input alloc_req_t r);
        alloc_rsp_t res;
        int         pos;
        int         g;
        int         w;
        int         b;
        int         k;
        res = '0;
        pos = -1;
        if (r.req_type == REQ_ALLOC)
        begin
            for (g = 0; g < NUM_GROUPS && pos < 0; g++)
            begin
                if (group_left[g] != 0)
                begin
                    for (w = g * WORDS_PER_GROUP; w < (g + 1) * WORDS_PER_GROUP && pos < 0; w++)
                    begin
                        for (b = 0; b < WORD_BITS && pos < 0 && !(&used_map[w]); b++)
                        begin
                            if (!used_map[w][b])
                                pos = w * WORD_BITS + b;
                        end
                    end
                end
            end
            if (pos < 0)
                res.status = ST_NO_SPACE;
            else
            begin
                used_map[pos / WORD_BITS][pos % WORD_BITS] = 1'b1;
                group_left[pos / BLOCKS_PER_GROUP]--;
                if (blocks_left > 0)
                    blocks_left--;
                res.block  = BLK_W'(pos + first_blk);
                res.status = ST_OK;
                live_pos.push_back(pos);
            end
        end
        else
        begin
            pos = int'(r.block_number) - int'(first_blk);
            if (pos < 0 || pos >= TOTAL_BLOCKS)
                res.status = ST_OUT_OF_RANGE;
            else if (!used_map[pos / WORD_BITS][pos % WORD_BITS])
                res.status = ST_ALREADY_FREE;
            else
            begin
                used_map[pos / WORD_BITS][pos % WORD_BITS] = 1'b0;
                group_left[pos / BLOCKS_PER_GROUP]++;
                blocks_left++;
                res.status = ST_OK;
                for (k = 0; k < live_pos.size(); k++)
                begin
                    if (live_pos[k] == pos)
                    begin
                        live_pos.delete(k);
                        break;
                    end
                end
            end
        end
        res.total_free = BLK_W'(blocks_left);
        return res;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        alloc_req_t word;
        if (rst_n && !(req_ch.valid && !req_taken))
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                word = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.req_type     <= word.req_type;
                req_ch.block_number <= word.block_number;
                req_gap = pick_wait(req_quiet);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response ready: waits a drawn number of cycles once a word is offered
    always @(negedge clk)
    begin
        if (rsp_taken)
            rsp_gap = pick_wait(rsp_quiet);
        if (!rst_n || stall_left > 0)
            rsp_ch.ready <= 1'b0;
        else if (rsp_gap == 0)
            rsp_ch.ready <= 1'b1;
        else
        begin
            if (rsp_ch.valid)
                rsp_gap--;
            rsp_ch.ready <= 1'b0;
        end
    end

    // one long hold-off on the response side so the request side backs up
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!stall_done && accepted_reqs >= 150)
        begin
            stall_left <= STALL_TICKS;
            stall_done <= 1'b1;
        end
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin
        alloc_req_t seen;
        alloc_rsp_t want;
        alloc_rsp_t got;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        rsp_taken <= rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            seen.req_type     = req_ch.req_type;
            seen.block_number = req_ch.block_number;
            expected_rsps.push_back(serve_request(seen));
            accepted_reqs <= accepted_reqs + 1;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.block      = rsp_ch.allocated_block;
            got.status     = rsp_ch.status;
            got.total_free = rsp_ch.total_free;
            if (expected_rsps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: block %0d status %0d free %0d",
                             got.block, got.status, got.total_free);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got.block !== want.block || got.status !== want.status ||
                    got.total_free !== want.total_free)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected block %0d status %0d free %0d, got block %0d status %0d free %0d",
                                 want.block, want.status, want.total_free,
                                 got.block, got.status, got.total_free);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** grouped_bitmap_block_allocator: FAILED **");
            $finish;
        end
    end

    task automatic set_first_block(input bit v);
        @(negedge clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.first_data_block <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        first_blk = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_req(input logic kind, input logic [BLK_W-1:0] blk);
        alloc_req_t word;
        word.req_type     = kind;
        word.block_number = blk;
        while (pending_reqs.size() >= 2)
            @(negedge clk);
        pending_reqs.push_back(word);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        int k;
        int pick;
        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.req_type         = REQ_ALLOC;
        req_ch.block_number     = '0;
        rsp_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.first_data_block = 1'b0;
        for (k = 0; k < NUM_GROUPS; k++)
            group_left[k] = BLOCKS_PER_GROUP;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first data block 0: block zero is a legal grant
        set_first_block(1'b0);
        queue_req(REQ_ALLOC, '0);
        queue_req(REQ_ALLOC, BLK_W'(TOTAL_BLOCKS));
        queue_req(REQ_ALLOC, 17'd12345);
        queue_req(REQ_FREE, 17'd1);
        queue_req(REQ_FREE, 17'd1);
        queue_req(REQ_ALLOC, '0);
        queue_req(REQ_FREE, BLK_W'(TOTAL_BLOCKS));
        queue_req(REQ_FREE, BLK_W'(TOTAL_BLOCKS - 1));
        queue_req(REQ_FREE, '0);
        queue_req(REQ_ALLOC, '0);
        wait_idle();

        // first data block 1: block 0 is below the device, the top one is valid
        set_first_block(1'b1);
        queue_req(REQ_FREE, '0);
        queue_req(REQ_FREE, BLK_W'(TOTAL_BLOCKS));
        queue_req(REQ_FREE, 17'd1);
        queue_req(REQ_ALLOC, '0);
        queue_req(REQ_FREE, 17'd3);
        queue_req(REQ_FREE, 17'd3);
        queue_req(REQ_FREE, BLK_W'(BLOCKS_PER_GROUP));
        queue_req(REQ_ALLOC, BLK_W'(TOTAL_BLOCKS));

        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            set_first_block(bit'(phase % 2));
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 58 || (pick < 90 && live_pos.size() == 0))
                    queue_req(REQ_ALLOC, BLK_W'($urandom_range(0, TOTAL_BLOCKS)));
                else if (pick < 90)
                begin
                    k = $urandom_range(0, live_pos.size() - 1);
                    queue_req(REQ_FREE, BLK_W'(live_pos[k] + first_blk));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       queue_req(REQ_FREE, '0);
                        1:       queue_req(REQ_FREE, BLK_W'(TOTAL_BLOCKS));
                        2:       queue_req(REQ_FREE, BLK_W'($urandom_range(0, TOTAL_BLOCKS)));
                        default: queue_req(REQ_FREE, BLK_W'($urandom_range(0, 2047)));
                    endcase
                end
            end
        end

        wait_idle();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("** grouped_bitmap_block_allocator: PASSED **");
        else
            $display("** grouped_bitmap_block_allocator: FAILED **");
        $finish;
    end

endmodule
